// File: rtl/tsrp_pkg.sv
// shared types and constants for the tiff sample row postprocess block
package tsrp_pkg;

  localparam int ByteW    = 8;
  localparam int SumW     = 16;
  localparam int CountW   = 19;
  localparam int CompW    = 6;
  localparam int WidthW   = 14;
  localparam int BitsW    = 5;
  localparam int CfgDataW = 14;
  localparam int CfgIdxW  = 3;
  localparam int Lanes    = 8;

  // sample width codes
  localparam logic [BitsW-1:0] Bps1  = 5'd1;
  localparam logic [BitsW-1:0] Bps2  = 5'd2;
  localparam logic [BitsW-1:0] Bps4  = 5'd4;
  localparam logic [BitsW-1:0] Bps8  = 5'd8;
  localparam logic [BitsW-1:0] Bps16 = 5'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BITS_PER_SAMPLE   = 3'd0,
    CFG_SAMPLES_PER_PIXEL = 3'd1,
    CFG_IMAGE_WIDTH       = 3'd2,
    CFG_PREDICTOR_ENABLE  = 3'd3,
    CFG_INVERT_ENABLE     = 3'd4,
    CFG_ALPHA_LAST        = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [BitsW-1:0]  bits;
    logic [CompW-1:0]  comps;
    logic [CountW-1:0] limit;
    logic              pred_en;
    logic              inv_en;
    logic              alpha_last;
  } proc_cfg_t;

  typedef struct packed {
    logic [1:0]       num;
    logic [ByteW-1:0] byte0;
    logic [ByteW-1:0] byte1;
  } step_res_t;

endpackage

// File: rtl/tsrp_if.sv
// stream channels for packed input bytes and processed output bytes
interface tsrp_in_if;
  logic                      valid;
  logic                      ready;
  logic [tsrp_pkg::ByteW-1:0] raw_byte;
  logic                      row_start;

  modport source (output valid, output raw_byte, output row_start, input ready);
  modport sink   (input valid, input raw_byte, input row_start, output ready);
endinterface

interface tsrp_out_if;
  logic                      valid;
  logic                      ready;
  logic [tsrp_pkg::ByteW-1:0] out_byte;
  logic                      last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// File: rtl/tsrp_engine.sv
// sample unpack, predictor decode, inversion and repack with per-row state
module tsrp_engine #(
  parameter int MAX_COMPONENTS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [tsrp_pkg::ByteW-1:0] raw_i,
  input  logic                       row_start_i,
  input  tsrp_pkg::proc_cfg_t        cfg_i,
  output tsrp_pkg::step_res_t        res_o
);

  localparam int IdxW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int Lanes = tsrp_pkg::Lanes;
  localparam int SumW  = tsrp_pkg::SumW;
  localparam int CompW = tsrp_pkg::CompW;
  localparam int CntW  = tsrp_pkg::CountW;

  logic [SumW-1:0]            sum_q [MAX_COMPONENTS];
  logic [SumW-1:0]            sum_d [MAX_COMPONENTS];
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [tsrp_pkg::ByteW-1:0] held_q;
  logic                       phase_q, phase_d;

  logic [IdxW-1:0]  base_idx;
  logic [CntW-1:0]  base_cnt;
  logic             base_phase;
  logic [IdxW-1:0]  k [0:Lanes];
  logic [SumW-1:0]  mask;
  logic [3:0]       n_present;
  logic [3:0]       n_act;
  logic [CntW-1:0]  rem;
  logic             is16;
  logic [SumW-1:0]  lane_val [Lanes];
  logic [SumW-1:0]  prev     [Lanes];
  logic [SumW-1:0]  pred     [Lanes];
  logic [SumW-1:0]  outv     [Lanes];
  logic             act      [Lanes];
  logic             inv      [Lanes];
  logic [3:0][1:0]  r2;
  logic [1:0][3:0]  r4;
  logic [3:0][1:0]  o2;
  logic [1:0][3:0]  o4;
  logic [7:0]       o1;

  assign base_idx   = row_start_i ? '0 : idx_q;
  assign base_cnt   = row_start_i ? '0 : cnt_q;
  assign base_phase = row_start_i ? 1'b0 : phase_q;
  assign is16       = (cfg_i.bits == tsrp_pkg::Bps16);
  assign r2         = raw_i;
  assign r4         = raw_i;

  // mode decode
  always_comb begin
    mask      = '0;
    n_present = '0;
    case (cfg_i.bits)
      tsrp_pkg::Bps1: begin
        mask      = 16'h0001;
        n_present = 4'd8;
      end
      tsrp_pkg::Bps2: begin
        mask      = 16'h0003;
        n_present = 4'd4;
      end
      tsrp_pkg::Bps4: begin
        mask      = 16'h000F;
        n_present = 4'd2;
      end
      tsrp_pkg::Bps8: begin
        mask      = 16'h00FF;
        n_present = 4'd1;
      end
      tsrp_pkg::Bps16: begin
        mask      = 16'hFFFF;
        n_present = base_phase ? 4'd1 : 4'd0;
      end
      default: begin
        mask      = '0;
        n_present = '0;
      end
    endcase
  end

  // samples left before padding
  always_comb begin
    rem = (base_cnt < cfg_i.limit) ? (cfg_i.limit - base_cnt) : '0;
    if (rem < CntW'(n_present)) begin
      n_act = rem[3:0];
    end else begin
      n_act = n_present;
    end
  end

  // unpack, msb first
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      lane_val[i] = '0;
    end
    case (cfg_i.bits)
      tsrp_pkg::Bps1: begin
        for (int i = 0; i < 8; i++) lane_val[i] = SumW'(raw_i[7-i]);
      end
      tsrp_pkg::Bps2: begin
        for (int i = 0; i < 4; i++) lane_val[i] = SumW'(r2[3-i]);
      end
      tsrp_pkg::Bps4: begin
        for (int i = 0; i < 2; i++) lane_val[i] = SumW'(r4[1-i]);
      end
      tsrp_pkg::Bps8: begin
        lane_val[0] = SumW'(raw_i);
      end
      tsrp_pkg::Bps16: begin
        lane_val[0] = {held_q, raw_i};
      end
      default: begin
        lane_val[0] = '0;
      end
    endcase
  end

  // component walk and per-lane predictor chain
  always_comb begin
    k[0] = (CompW'(base_idx) >= cfg_i.comps) ? '0 : base_idx;
    for (int i = 0; i < Lanes; i++) begin
      if (CompW'(k[i]) + CompW'(1) == cfg_i.comps) begin
        k[i+1] = '0;
      end else begin
        k[i+1] = k[i] + IdxW'(1);
      end
    end
    for (int i = 0; i < Lanes; i++) begin
      act[i]  = (4'(i) < n_act);
      prev[i] = row_start_i ? '0 : sum_q[k[i]];
      // same component seen earlier in this byte: chain from that lane
      for (int j = 0; j < i; j++) begin
        if (CompW'(i - j) == cfg_i.comps) prev[i] = pred[j];
      end
      pred[i] = cfg_i.pred_en ? ((lane_val[i] + prev[i]) & mask) : lane_val[i];
      inv[i]  = cfg_i.inv_en &&
                !(cfg_i.alpha_last && (CompW'(k[i]) == cfg_i.comps - CompW'(1)));
      if (act[i]) begin
        outv[i] = (inv[i] ? (pred[i] ^ mask) : pred[i]) & mask;
      end else begin
        outv[i] = lane_val[i];
      end
    end
  end

  // repack
  always_comb begin
    for (int i = 0; i < 8; i++) o1[7-i] = outv[i][0];
    for (int i = 0; i < 4; i++) o2[3-i] = outv[i][1:0];
    for (int i = 0; i < 2; i++) o4[1-i] = outv[i][3:0];
    res_o.num   = 2'd1;
    res_o.byte0 = raw_i;
    res_o.byte1 = outv[0][7:0];
    case (cfg_i.bits)
      tsrp_pkg::Bps1:  res_o.byte0 = o1;
      tsrp_pkg::Bps2:  res_o.byte0 = o2;
      tsrp_pkg::Bps4:  res_o.byte0 = o4;
      tsrp_pkg::Bps8:  res_o.byte0 = outv[0][7:0];
      tsrp_pkg::Bps16: begin
        res_o.num   = base_phase ? 2'd2 : 2'd0;
        res_o.byte0 = outv[0][15:8];
      end
      default: res_o.byte0 = raw_i;
    endcase
  end

  // next state
  always_comb begin
    for (int e = 0; e < MAX_COMPONENTS; e++) begin
      sum_d[e] = row_start_i ? '0 : sum_q[e];
      for (int i = 0; i < Lanes; i++) begin
        if (cfg_i.pred_en && act[i] && (k[i] == IdxW'(e))) sum_d[e] = pred[i];
      end
    end
    idx_d   = (n_act == 4'd0) ? base_idx : k[n_act];
    cnt_d   = base_cnt + CntW'(n_act);
    phase_d = is16 ? !base_phase : 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < MAX_COMPONENTS; e++) sum_q[e] <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      held_q  <= '0;
      phase_q <= 1'b0;
    end else if (step_i) begin
      for (int e = 0; e < MAX_COMPONENTS; e++) sum_q[e] <= sum_d[e];
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      if (is16 && !base_phase) held_q <= raw_i;
    end
  end

endmodule

// File: rtl/tiff_sample_row_postprocess_top.sv
// Takes one packed TIFF sample byte per cycle and gives one processed byte per cycle
// (1, 2, 4 or 8 bits per sample) while the output is not stalled, or, at 16 bits,
// nothing on the high byte and the high and low result bytes after the low byte.
// A byte goes from the input register through the sample datapath into a two-entry
// output buffer; the running component sums sit in flip-flops and are updated as the
// result enters the buffer, which lets the next byte follow at once. Sustained rate is
// one input byte and one output byte per cycle while the output is not stalled, set
// by the single sample datapath and the one-byte output port. last_of_run marks the
// final result byte of each input byte. Configuration is registered on the write,
// and the row limit (width times components) is registered from it once more.
module tiff_sample_row_postprocess_top #(
  parameter int MAX_COMPONENTS = 32,
  parameter int MAX_WIDTH      = 8192
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tsrp_in_if.sink                       in_i,
  tsrp_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [tsrp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tsrp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int CompW  = tsrp_pkg::CompW;
  localparam int CntW   = tsrp_pkg::CountW;
  localparam int WidthW = tsrp_pkg::WidthW;
  localparam int WidthClip = (MAX_WIDTH > (2**WidthW - 1)) ? (2**WidthW - 1) : MAX_WIDTH;
  localparam logic [CompW-1:0]  MaxComps = CompW'(MAX_COMPONENTS);
  localparam logic [WidthW-1:0] MaxWidth = WidthW'(WidthClip);

  // configuration registers
  logic [tsrp_pkg::BitsW-1:0] cfg_bits_q;
  logic [CompW-1:0]           cfg_spp_q;
  logic [WidthW-1:0]          cfg_width_q;
  logic                       cfg_pred_q, cfg_inv_q, cfg_alpha_q;
  logic [CompW-1:0]           comps_d, comps_q;
  logic [WidthW-1:0]          width_eff;
  logic [CntW-1:0]            limit_d, limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bits_q  <= tsrp_pkg::Bps8;
      cfg_spp_q   <= CompW'(1);
      cfg_width_q <= WidthW'(1);
      cfg_pred_q  <= 1'b0;
      cfg_inv_q   <= 1'b0;
      cfg_alpha_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tsrp_pkg::CFG_BITS_PER_SAMPLE:   cfg_bits_q  <= cfg_data_i[tsrp_pkg::BitsW-1:0];
        tsrp_pkg::CFG_SAMPLES_PER_PIXEL: cfg_spp_q   <= cfg_data_i[CompW-1:0];
        tsrp_pkg::CFG_IMAGE_WIDTH:       cfg_width_q <= cfg_data_i[WidthW-1:0];
        tsrp_pkg::CFG_PREDICTOR_ENABLE:  cfg_pred_q  <= cfg_data_i[0];
        tsrp_pkg::CFG_INVERT_ENABLE:     cfg_inv_q   <= cfg_data_i[0];
        tsrp_pkg::CFG_ALPHA_LAST:        cfg_alpha_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_spp_q == '0) begin
      comps_d = CompW'(1);
    end else if (cfg_spp_q > MaxComps) begin
      comps_d = MaxComps;
    end else begin
      comps_d = cfg_spp_q;
    end
    width_eff = (cfg_width_q > MaxWidth) ? MaxWidth : cfg_width_q;
    limit_d   = CntW'(width_eff) * CntW'(comps_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comps_q <= CompW'(1);
      limit_q <= CntW'(1);
    end else begin
      comps_q <= comps_d;
      limit_q <= limit_d;
    end
  end

  tsrp_pkg::proc_cfg_t pcfg;
  assign pcfg.bits       = cfg_bits_q;
  assign pcfg.comps      = comps_q;
  assign pcfg.limit      = limit_q;
  assign pcfg.pred_en    = cfg_pred_q;
  assign pcfg.inv_en     = cfg_inv_q;
  assign pcfg.alpha_last = cfg_alpha_q;

  // input register
  logic                       in_vld_q;
  logic [tsrp_pkg::ByteW-1:0] in_byte_q;
  logic                       in_rs_q;
  logic                       fire;
  logic                       in_xfer;

  assign in_i.ready = !in_vld_q || fire;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= in_i.raw_byte;
      in_rs_q   <= in_i.row_start;
    end
  end

  tsrp_pkg::step_res_t res;

  tsrp_engine #(
    .MAX_COMPONENTS(MAX_COMPONENTS)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .step_i      (fire),
    .raw_i       (in_byte_q),
    .row_start_i (in_rs_q),
    .cfg_i       (pcfg),
    .res_o       (res)
  );

  // two-entry output buffer, head at entry 0
  logic [tsrp_pkg::ByteW-1:0] ob_byte_q [2];
  logic [tsrp_pkg::ByteW-1:0] ob_byte_d [2];
  logic                       ob_last_q [2];
  logic                       ob_last_d [2];
  logic [1:0]                 ob_cnt_q, ob_cnt_d;
  logic [1:0]                 cnt_pop, free;
  logic                       pop;

  always_comb begin
    pop       = (ob_cnt_q != 2'd0) && out_o.ready;
    cnt_pop   = ob_cnt_q - 2'(pop);
    free      = 2'd2 - cnt_pop;
    fire      = in_vld_q && (res.num <= free);
    ob_byte_d = ob_byte_q;
    ob_last_d = ob_last_q;
    if (pop) begin
      ob_byte_d[0] = ob_byte_q[1];
      ob_last_d[0] = ob_last_q[1];
    end
    if (fire) begin
      case (res.num)
        2'd1: begin
          ob_byte_d[cnt_pop[0]] = res.byte0;
          ob_last_d[cnt_pop[0]] = 1'b1;
        end
        2'd2: begin
          ob_byte_d[0] = res.byte0;
          ob_last_d[0] = 1'b0;
          ob_byte_d[1] = res.byte1;
          ob_last_d[1] = 1'b1;
        end
        default: ;
      endcase
    end
    ob_cnt_d = cnt_pop + (fire ? res.num : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_cnt_q <= '0;
    end else begin
      ob_cnt_q <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_byte_q <= ob_byte_d;
    ob_last_q <= ob_last_d;
  end

  assign out_o.valid       = (ob_cnt_q != 2'd0);
  assign out_o.out_byte    = ob_byte_q[0];
  assign out_o.last_of_run = ob_last_q[0];

  // buffer never holds more than a 16-bit pair
  a_ob_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ob_cnt_q != 2'd3)
    else $error("output buffer overfilled");

  // a 16-bit sample lands as high byte then low byte, only the low one closing the run
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (res.num == 2'd2) |=> (ob_cnt_q == 2'd2) && !ob_last_q[0] && ob_last_q[1])
    else $error("16-bit result pair misplaced");

  // a held input byte is not dropped while the buffer is full
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !fire |=> in_vld_q && $stable(in_byte_q))
    else $error("stalled input byte lost");

endmodule

// File: sim/tiff_sample_row_postprocess_top_test.sv
// self-checking test of the tiff row postprocess block with a predicting byte scoreboard
`timescale 1ns / 100ps

module tiff_sample_row_postprocess_top_test;

  localparam int MaxComps = 32;
  localparam int MaxWidth = 8192;

  typedef struct packed {
    logic [tsrp_pkg::ByteW-1:0] data;
    logic                       last;
  } result_beat_t;

  // predicts the output bytes of every input byte and checks them in order
  class row_byte_scoreboard;
    logic [tsrp_pkg::BitsW-1:0]  bps;
    logic [tsrp_pkg::CompW-1:0]  spp;
    logic [tsrp_pkg::WidthW-1:0] img_w;
    logic                        pred_en;
    logic                        inv_en;
    logic                        alpha_en;
    logic [tsrp_pkg::SumW-1:0]   comp_sum[MaxComps];
    int unsigned                 comp_idx;
    int unsigned                 sample_cnt;
    logic [tsrp_pkg::ByteW-1:0]  held_hi;
    logic                        hi_phase;
    result_beat_t                expected_bytes[$];
    int unsigned                 errors;
    int unsigned                 inputs_seen;
    int unsigned                 results_seen;

    function new();
      bps = tsrp_pkg::Bps8;
      spp = 1;
      img_w = 1;
      pred_en = 1'b0;
      inv_en = 1'b0;
      alpha_en = 1'b0;
      foreach (comp_sum[i]) comp_sum[i] = '0;
      comp_idx = 0;
      sample_cnt = 0;
      held_hi = '0;
      hi_phase = 1'b0;
      errors = 0;
      inputs_seen = 0;
      results_seen = 0;
    endfunction

    function void set_reg(tsrp_pkg::cfg_reg_e r, logic [tsrp_pkg::CfgDataW-1:0] v);
      case (r)
        tsrp_pkg::CFG_BITS_PER_SAMPLE:   bps = v[tsrp_pkg::BitsW-1:0];
        tsrp_pkg::CFG_SAMPLES_PER_PIXEL: spp = v[tsrp_pkg::CompW-1:0];
        tsrp_pkg::CFG_IMAGE_WIDTH:       img_w = v[tsrp_pkg::WidthW-1:0];
        tsrp_pkg::CFG_PREDICTOR_ENABLE:  pred_en = v[0];
        tsrp_pkg::CFG_INVERT_ENABLE:     inv_en = v[0];
        tsrp_pkg::CFG_ALPHA_LAST:        alpha_en = v[0];
        default: ;
      endcase
    endfunction

    function int unsigned comp_count();
      if (spp == 0) return 1;
      if (spp > MaxComps) return MaxComps;
      return spp;
    endfunction

    // one unpacked sample through differencing decode and inversion
    function int unsigned decode_sample(int unsigned v, int unsigned mask);
      int unsigned comps;
      int unsigned k;
      int unsigned wpx;
      comps = comp_count();
      wpx = (img_w > MaxWidth) ? MaxWidth : img_w;
      // padding past the row passes through untouched
      if (sample_cnt >= wpx * comps) return v;
      k = (comp_idx >= comps) ? 0 : comp_idx;
      if (pred_en) begin
        v = (v + comp_sum[k]) & mask;
        comp_sum[k] = v[tsrp_pkg::SumW-1:0];
      end
      if (inv_en && !(alpha_en && k == comps - 1)) v = mask - v;
      k++;
      comp_idx = (k >= comps) ? 0 : k;
      if (sample_cnt < 'h7FFFF) sample_cnt++;
      return v & mask;
    endfunction

    function void note_input(logic [tsrp_pkg::ByteW-1:0] raw, logic rs);
      logic [tsrp_pkg::ByteW-1:0] packed_out;
      logic [tsrp_pkg::SumW-1:0]  word;
      int unsigned                mask;
      int                         pos;
      inputs_seen++;
      if (rs) begin
        foreach (comp_sum[i]) comp_sum[i] = '0;
        comp_idx = 0;
        sample_cnt = 0;
        hi_phase = 1'b0;
      end
      if (bps == tsrp_pkg::Bps16) begin
        if (!hi_phase) begin
          held_hi = raw;
          hi_phase = 1'b1;
          return;
        end
        hi_phase = 1'b0;
        word = tsrp_pkg::SumW'(decode_sample({held_hi, raw}, 'hFFFF));
        expected_bytes.push_back('{data: word[15:8], last: 1'b0});
        expected_bytes.push_back('{data: word[7:0], last: 1'b1});
        return;
      end
      hi_phase = 1'b0;
      packed_out = raw;
      // unsupported widths pass the byte through
      if (bps == tsrp_pkg::Bps1 || bps == tsrp_pkg::Bps2 || bps == tsrp_pkg::Bps4 ||
          bps == tsrp_pkg::Bps8) begin
        mask = (1 << bps) - 1;
        packed_out = '0;
        for (pos = tsrp_pkg::ByteW - int'(bps); pos >= 0; pos -= int'(bps))
          packed_out |= tsrp_pkg::ByteW'(decode_sample((raw >> pos) & mask, mask) << pos);
      end
      expected_bytes.push_back('{data: packed_out, last: 1'b1});
    endfunction

    function void check_result(logic [tsrp_pkg::ByteW-1:0] data, logic last);
      result_beat_t want;
      results_seen++;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result byte %02h last %0b", data, last);
        return;
      end
      want = expected_bytes.pop_front();
      if (want.data !== data || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                   results_seen, want.data, want.last, data, last);
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [tsrp_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [tsrp_pkg::CfgDataW-1:0] cfg_data_i;

  tsrp_in_if  in_ch ();
  tsrp_out_if out_ch ();

  tiff_sample_row_postprocess_top #(
    .MAX_COMPONENTS(MaxComps),
    .MAX_WIDTH     (MaxWidth)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_o     (out_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  row_byte_scoreboard sb = new();

  logic        in_busy;
  logic        out_busy;
  int unsigned items_sent;
  int unsigned settings_run;

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  initial begin
    #(400_000);
    $display("tiff_sample_row_postprocess_top test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_input(in_ch.raw_byte, in_ch.row_start);
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.out_byte, out_ch.last_of_run);
  end

  // receiving side: random stall before each result transfer while out_busy is set
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = out_busy ? $urandom_range(0, 3) : 0;
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      @(negedge clk_i);
    end
  end

  task automatic send_byte(input logic [tsrp_pkg::ByteW-1:0] b, input logic rs);
    int unsigned gap;
    gap = in_busy ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.raw_byte = b;
    in_ch.row_start = rs;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // stop sending and let every expected byte drain
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic write_reg(input tsrp_pkg::cfg_reg_e r, input int unsigned v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = r;
    cfg_data_i = tsrp_pkg::CfgDataW'(v);
    sb.set_reg(r, tsrp_pkg::CfgDataW'(v));
  endtask

  task automatic apply_config(input int unsigned b, input int unsigned c, input int unsigned w,
                              input logic p, input logic i, input logic a);
    settle();
    write_reg(tsrp_pkg::CFG_BITS_PER_SAMPLE, b);
    write_reg(tsrp_pkg::CFG_SAMPLES_PER_PIXEL, c);
    write_reg(tsrp_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(tsrp_pkg::CFG_PREDICTOR_ENABLE, p);
    write_reg(tsrp_pkg::CFG_INVERT_ENABLE, i);
    write_reg(tsrp_pkg::CFG_ALPHA_LAST, a);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    // wait for the registered row limit to follow the new settings
    @(negedge clk_i);
    settings_run++;
  endtask

  // mostly whole rows with random content, some broken rows and stray row starts
  task automatic run_rows(input int unsigned budget, input logic cont);
    int unsigned comps;
    int unsigned wpx;
    int unsigned nbytes;
    int unsigned len;
    int unsigned n;
    logic        legal;
    logic        first;
    logic        rs;
    comps = sb.comp_count();
    wpx = (sb.img_w > MaxWidth) ? MaxWidth : sb.img_w;
    legal = (sb.bps == tsrp_pkg::Bps1 || sb.bps == tsrp_pkg::Bps2 ||
             sb.bps == tsrp_pkg::Bps4 || sb.bps == tsrp_pkg::Bps8 ||
             sb.bps == tsrp_pkg::Bps16);
    nbytes = legal ? (wpx * comps * sb.bps + 7) / 8 : $urandom_range(1, 6);
    if (nbytes > 40) nbytes = 40;
    n = 0;
    first = 1'b1;
    while (n < budget) begin
      len = nbytes + $urandom_range(0, 2) * ((sb.bps == tsrp_pkg::Bps16) ? 2 : 1);
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 9);
      for (int j = 0; j < len && n < budget; j++) begin
        rs = (j == 0) && !(first && cont);
        if ($urandom_range(0, 29) == 0) rs = ~rs;
        send_byte(8'($urandom_range(0, 255)), rs);
        n++;
      end
      first = 1'b0;
    end
  endtask

  initial begin
    int unsigned goal;
    int unsigned pick;
    int unsigned r_bits;
    int unsigned r_comps;
    int unsigned r_width;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = tsrp_pkg::CFG_BITS_PER_SAMPLE;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.raw_byte = '0;
    in_ch.row_start = 1'b0;
    in_busy = 1'b1;
    out_busy = 1'b1;
    items_sent = 0;
    settings_run = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: one sample per row, the rest is padding
    send_byte(8'h80, 1'b1);
    send_byte(8'hFF, 1'b0);

    // single-bit samples, three components with alpha, row ends inside a byte
    apply_config(tsrp_pkg::Bps1, 3, 2, 1'b1, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);

    // 16-bit samples with wraparound, padding, and a high byte left waiting
    apply_config(tsrp_pkg::Bps16, 2, 1, 1'b1, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b0);
    // switching width drops the waiting high byte
    apply_config(tsrp_pkg::Bps8, 2, 1, 1'b1, 1'b1, 1'b0);
    send_byte(8'h34, 1'b0);
    apply_config(tsrp_pkg::Bps16, 2, 2, 1'b1, 1'b1, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hCD, 1'b0);

    // unsupported sample width passes through
    apply_config(3, 1, 1, 1'b1, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b0);

    // zero components and a width above the maximum
    apply_config(tsrp_pkg::Bps4, 0, 16383, 1'b1, 1'b0, 1'b0);
    send_byte(8'h12, 1'b1);
    send_byte(8'hF7, 1'b0);

    // fewer components mid-row leaves a stale component index
    apply_config(tsrp_pkg::Bps2, 3, 8192, 1'b1, 1'b1, 1'b1);
    send_byte(8'h1B, 1'b1);
    send_byte(8'hE4, 1'b0);
    apply_config(tsrp_pkg::Bps2, 2, 8192, 1'b1, 1'b1, 1'b0);
    send_byte(8'h55, 1'b0);

    // component count above the maximum, alpha on the last one
    apply_config(tsrp_pkg::Bps8, 63, 5, 1'b0, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);

    goal = items_sent + 600;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1:    r_bits = tsrp_pkg::Bps1;
        2:       r_bits = tsrp_pkg::Bps2;
        3:       r_bits = tsrp_pkg::Bps4;
        4, 5:    r_bits = tsrp_pkg::Bps8;
        6, 7:    r_bits = tsrp_pkg::Bps16;
        default: r_bits = $urandom_range(0, 31);
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        6:       r_comps = MaxComps;
        7:       r_comps = 0;
        8:       r_comps = $urandom_range(33, 63);
        9:       r_comps = $urandom_range(0, 63);
        default: r_comps = $urandom_range(1, 4);
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        7:       r_width = MaxWidth;
        8:       r_width = 16383;
        9:       r_width = $urandom_range(1, 16383);
        default: r_width = $urandom_range(1, 12);
      endcase
      apply_config(r_bits, r_comps, r_width, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      in_busy = ($urandom_range(0, 3) != 0);
      out_busy = ($urandom_range(0, 3) != 0);
      run_rows($urandom_range(15, 60), $urandom_range(0, 2) == 0);
    end

    settle();
    $display("covered %0d input bytes and %0d result bytes over %0d register settings",
             sb.inputs_seen, sb.results_seen, settings_run);
    $display("%0d mismatching or unexpected result bytes", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tiff_sample_row_postprocess_top test passed");
    end else begin
      $display("tiff_sample_row_postprocess_top test failed");
    end
    $finish;
  end

endmodule
